### rtl/tlr_pkg.sv
// ----------------------------------------------------------------------------
// tlr_pkg
// Types and constants shared by the telnet line receiver: result kinds,
// telnet command and option bytes, and the burst descriptor that carries the
// results of one received byte.
// ----------------------------------------------------------------------------
package tlr_pkg;

  // Result kinds as seen on the result channel.
  localparam logic [2:0] K_APPEND    = 3'd0;
  localparam logic [2:0] K_ERASE     = 3'd1;
  localparam logic [2:0] K_LINE_END  = 3'd2;
  localparam logic [2:0] K_REPLY     = 3'd3;
  localparam logic [2:0] K_COMPRESS  = 3'd4;
  localparam logic [2:0] K_WIN_SIZE  = 3'd5;
  localparam logic [2:0] K_TYPE_CHAR = 3'd6;
  localparam logic [2:0] K_TYPE_END  = 3'd7;

  // Telnet command bytes.
  localparam logic [7:0] TN_IAC  = 8'd255;
  localparam logic [7:0] TN_DONT = 8'd254;
  localparam logic [7:0] TN_DO   = 8'd253;
  localparam logic [7:0] TN_WONT = 8'd252;
  localparam logic [7:0] TN_WILL = 8'd251;
  localparam logic [7:0] TN_SB   = 8'd250;
  localparam logic [7:0] TN_SE   = 8'd240;

  // Telnet options and subnegotiation codes.
  localparam logic [7:0] OPT_ECHO      = 8'd1;
  localparam logic [7:0] OPT_TTYPE     = 8'd24;
  localparam logic [7:0] OPT_NAWS      = 8'd31;
  localparam logic [7:0] OPT_COMPRESS1 = 8'd85;
  localparam logic [7:0] OPT_COMPRESS2 = 8'd86;
  localparam logic [7:0] TTYPE_SEND    = 8'd1;

  // Text bytes with a meaning of their own.
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // Shapes of result bursts.
  localparam logic [1:0] B_ONE    = 2'd0;  // a single result from the descriptor
  localparam logic [1:0] B_WONT   = 2'd1;  // IAC WONT option
  localparam logic [1:0] B_TTYPE  = 2'd2;  // terminal type SEND subnegotiation
  localparam logic [1:0] B_APPEND = 2'd3;  // append followed by a forced line end

  typedef struct packed {
    logic [1:0]  bkind;
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [11:0] position;
    logic [15:0] win_width;
    logic [15:0] win_height;
  } tlr_burst_t;

  // Number of results in a burst of the given shape.
  function automatic logic [2:0] burst_count(input logic [1:0] bkind);
    logic [2:0] n;
    case (bkind)
      B_ONE:    n = 3'd1;
      B_WONT:   n = 3'd3;
      B_TTYPE:  n = 3'd6;
      B_APPEND: n = 3'd2;
      default:  n = 3'd1;
    endcase
    return n;
  endfunction

  // Bytes of the terminal type query: IAC SB TTYPE SEND IAC SE.
  function automatic logic [7:0] ttype_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = TN_IAC;
      3'd1:    b = TN_SB;
      3'd2:    b = OPT_TTYPE;
      3'd3:    b = TTYPE_SEND;
      3'd4:    b = TN_IAC;
      3'd5:    b = TN_SE;
      default: b = TN_SE;
    endcase
    return b;
  endfunction

endpackage

### rtl/tlr_if.sv
// ----------------------------------------------------------------------------
// tlr_byte_if / tlr_result_if
// Valid/ready channels of the telnet line receiver: one for received bytes
// and one for result requests.
// ----------------------------------------------------------------------------
interface tlr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tlr_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data;
  logic [11:0] position;
  logic [15:0] win_width;
  logic [15:0] win_height;
  logic        last;

  modport source (output valid, output kind, output data, output position,
                  output win_width, output win_height, output last, input ready);
  modport sink   (input valid, input kind, input data, input position,
                  input win_width, input win_height, input last, output ready);
endinterface

### rtl/tlr_parser.sv
// ----------------------------------------------------------------------------
// tlr_parser
// Parse state of the telnet line receiver. Decodes one byte per step into a
// result burst descriptor and advances the line, command and subnegotiation
// state.
// ----------------------------------------------------------------------------
module tlr_parser #(
  parameter int LINE_MAX = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         rx_byte,
  output logic               has_res,
  output tlr_pkg::tlr_burst_t desc
);
  import tlr_pkg::*;

  localparam int LPW = $clog2(LINE_MAX);
  localparam logic [LPW-1:0] LP_LAST = LPW'(LINE_MAX - 2);

  // Parser modes.
  localparam logic [2:0] M_TEXT = 3'd0;
  localparam logic [2:0] M_CMD  = 3'd1;
  localparam logic [2:0] M_DONT = 3'd2;
  localparam logic [2:0] M_DO   = 3'd3;
  localparam logic [2:0] M_WILL = 3'd4;
  localparam logic [2:0] M_WONT = 3'd5;
  localparam logic [2:0] M_SUB  = 3'd6;

  logic [2:0]      mode_r, mode_nxt;
  logic [LPW-1:0]  lp_r, lp_nxt;
  logic [7:0]      sub_opt_r, sub_opt_nxt;
  logic [2:0]      sub_idx_r, sub_idx_nxt;
  logic [3:0][7:0] size_r, size_nxt;
  logic            stopped_r, stopped_nxt;

  // Line position as seen on the 12-bit position field.
  function automatic logic [11:0] pos12(input logic [LPW-1:0] v);
    logic [LPW+11:0] e;
    e = {12'd0, v};
    return e[11:0];
  endfunction

  // Decode of the current byte against the parse state.
  always_comb begin
    mode_nxt    = mode_r;
    lp_nxt      = lp_r;
    sub_opt_nxt = sub_opt_r;
    sub_idx_nxt = sub_idx_r;
    size_nxt    = size_r;
    stopped_nxt = stopped_r;
    has_res     = 1'b0;
    desc        = '0;
    desc.bkind  = B_ONE;
    case (mode_r)
      M_TEXT: begin
        if (rx_byte == TN_IAC) begin
          mode_nxt = M_CMD;
        end else if (rx_byte <= CH_SPACE && lp_r == '0) begin
          has_res   = 1'b1;
          desc.kind = K_LINE_END;
        end else if ((rx_byte inside {CH_BS, CH_DEL}) && lp_r != '0) begin
          lp_nxt        = lp_r - 1'b1;
          has_res       = 1'b1;
          desc.kind     = K_ERASE;
          desc.position = pos12(lp_r - 1'b1);
        end else if (rx_byte < CH_SPACE) begin
          has_res       = 1'b1;
          desc.kind     = K_LINE_END;
          desc.position = pos12(lp_r);
          lp_nxt        = '0;
        end else begin
          has_res       = 1'b1;
          desc.kind     = K_APPEND;
          desc.data     = rx_byte;
          desc.position = pos12(lp_r);
          if (lp_r >= LP_LAST) begin
            desc.bkind = B_APPEND;
            lp_nxt     = '0;
          end else begin
            lp_nxt = lp_r + 1'b1;
          end
        end
      end
      M_CMD: begin
        case (rx_byte)
          TN_DONT: mode_nxt = M_DONT;
          TN_DO:   mode_nxt = M_DO;
          TN_WILL: mode_nxt = M_WILL;
          TN_WONT: mode_nxt = M_WONT;
          TN_SB: begin
            mode_nxt    = M_SUB;
            sub_opt_nxt = '0;
            sub_idx_nxt = '0;
            size_nxt    = '0;
            stopped_nxt = 1'b0;
          end
          default: mode_nxt = M_TEXT;
        endcase
      end
      M_DONT: begin
        has_res    = 1'b1;
        desc.bkind = B_WONT;
        desc.kind  = K_REPLY;
        desc.data  = rx_byte;
        mode_nxt   = M_TEXT;
      end
      M_DO: begin
        if (rx_byte == OPT_COMPRESS2) begin
          has_res   = 1'b1;
          desc.kind = K_COMPRESS;
          desc.data = 8'd2;
        end else if (rx_byte == OPT_COMPRESS1) begin
          has_res   = 1'b1;
          desc.kind = K_COMPRESS;
          desc.data = 8'd1;
        end else if (rx_byte != OPT_ECHO) begin
          has_res    = 1'b1;
          desc.bkind = B_WONT;
          desc.kind  = K_REPLY;
          desc.data  = rx_byte;
        end
        mode_nxt = M_TEXT;
      end
      M_WILL: begin
        if (rx_byte == OPT_TTYPE) begin
          has_res    = 1'b1;
          desc.bkind = B_TTYPE;
          desc.kind  = K_REPLY;
        end
        mode_nxt = M_TEXT;
      end
      M_WONT: begin
        mode_nxt = M_TEXT;
      end
      M_SUB: begin
        if (rx_byte == TN_SE) begin
          if (sub_idx_r != '0 && sub_opt_r == OPT_NAWS) begin
            has_res         = 1'b1;
            desc.kind       = K_WIN_SIZE;
            desc.win_width  = {size_r[0], size_r[1]};
            desc.win_height = {size_r[2], size_r[3]};
          end else if (sub_idx_r != '0 && sub_opt_r == OPT_TTYPE) begin
            has_res   = 1'b1;
            desc.kind = K_TYPE_END;
          end
          mode_nxt = M_TEXT;
        end else begin
          if (sub_idx_r == '0) begin
            sub_opt_nxt = rx_byte;
          end else if (sub_opt_r == OPT_NAWS) begin
            if (sub_idx_r <= 3'd4) begin
              size_nxt[2'(sub_idx_r - 1'b1)] = rx_byte;
            end
          end else if (sub_opt_r == OPT_TTYPE && sub_idx_r >= 3'd2) begin
            if (rx_byte == TN_IAC) begin
              stopped_nxt = 1'b1;
            end else if (!stopped_r) begin
              has_res   = 1'b1;
              desc.kind = K_TYPE_CHAR;
              desc.data = rx_byte;
            end
          end
          if (sub_idx_r != 3'd7) begin
            sub_idx_nxt = sub_idx_r + 1'b1;
          end
        end
      end
      default: begin
        mode_nxt = M_TEXT;
      end
    endcase
  end

  // State registers advance once per processed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_TEXT;
      lp_r      <= '0;
      sub_opt_r <= '0;
      sub_idx_r <= '0;
      size_r    <= '0;
      stopped_r <= 1'b0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      lp_r      <= lp_nxt;
      sub_opt_r <= sub_opt_nxt;
      sub_idx_r <= sub_idx_nxt;
      size_r    <= size_nxt;
      stopped_r <= stopped_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // The line never holds more than LINE_MAX-2 characters between bytes.
  a_lp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lp_r <= LP_LAST)
    else $error("line position beyond line limit");

  // The line position only moves on a byte taken in text mode.
  a_lp_text: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && lp_r != $past(lp_r) |-> $past(mode_r) == M_TEXT && $past(step))
    else $error("line position moved outside text mode");

  // Terminal type streaming stops only inside a subnegotiation.
  a_stop_sub: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(stopped_r) |-> $past(mode_r) == M_SUB)
    else $error("type stop set outside subnegotiation");
`endif

endmodule

### rtl/telnet_line_receiver.sv
// A byte accepted into the input register is decoded by the parser, and its
// burst is loaded into the burst register, from which its results are offered.
// Throughput: one byte per cycle while the burst register is free. Results
// leave at one per cycle while the receiver is ready; a reply of three or six
// bytes holds input until it drains. Bytes with no result never wait.
// Reset: synchronous, active low; returns to text mode with an empty line.
// ----------------------------------------------------------------------------
// telnet_line_receiver
// Splits received telnet bytes into line editing requests and option
// negotiation replies. An input register feeds the parser; a result register
// holds its burst descriptor and unrolls it one request a cycle while ready.
// ----------------------------------------------------------------------------
module telnet_line_receiver #(
  parameter int LINE_MAX = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  tlr_byte_if.sink      in_ch,
  tlr_result_if.source  out_ch
);
  import tlr_pkg::*;

  logic       in_v_r;
  logic [7:0] in_b_r;
  logic       burst_v_r;
  tlr_burst_t desc_r;
  logic [2:0] idx_r;

  logic       has_res;
  tlr_burst_t desc;
  logic       last_now;
  logic       out_fire;
  logic       drain;
  logic       step;

  tlr_parser #(.LINE_MAX(LINE_MAX)) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_b_r),
    .has_res (has_res),
    .desc    (desc)
  );

  // Handshake between the input register and the burst register.
  assign last_now = idx_r == burst_count(desc_r.bkind) - 1'b1;
  assign out_fire = burst_v_r && out_ch.ready;
  assign drain    = out_fire && last_now;
  assign step     = in_v_r && (!has_res || !burst_v_r || drain);
  assign in_ch.ready = !in_v_r || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_b_r <= in_ch.rx_byte;
    end
  end

  // Burst register and request index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_v_r <= 1'b0;
      idx_r     <= '0;
    end else if (step && has_res) begin
      burst_v_r <= 1'b1;
      idx_r     <= '0;
    end else if (drain) begin
      burst_v_r <= 1'b0;
    end else if (out_fire) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (step && has_res) begin
      desc_r <= desc;
    end
  end

  // Request fields for the current place in the burst.
  always_comb begin
    out_ch.valid      = burst_v_r;
    out_ch.last       = last_now;
    out_ch.kind       = desc_r.kind;
    out_ch.data       = desc_r.data;
    out_ch.position   = desc_r.position;
    out_ch.win_width  = desc_r.win_width;
    out_ch.win_height = desc_r.win_height;
    case (desc_r.bkind)
      B_ONE: begin
      end
      B_WONT: begin
        if (idx_r == 3'd0) begin
          out_ch.data = TN_IAC;
        end else if (idx_r == 3'd1) begin
          out_ch.data = TN_WONT;
        end
      end
      B_TTYPE: begin
        out_ch.data = ttype_byte(idx_r);
      end
      B_APPEND: begin
        if (idx_r != 3'd0) begin
          out_ch.kind     = K_LINE_END;
          out_ch.data     = '0;
          out_ch.position = desc_r.position + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // The request index stays inside the burst.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    burst_v_r |-> idx_r < burst_count(desc_r.bkind))
    else $error("burst index beyond burst length");

  // A byte waiting for the burst register is held unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !step |=> in_v_r && $stable(in_b_r))
    else $error("waiting byte lost or changed");

  // A finished burst with nothing behind it leaves the result channel idle.
  a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
    drain && !(step && has_res) |=> !burst_v_r)
    else $error("result offered after burst drained");
`endif

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the telnet line receiver against a behavioural predictor. Received
// bytes are sent through the byte channel with random gaps, and every result
// request is compared field by field with the requests predicted for the
// accepted bytes, in order. Directed tests cover line editing, option replies
// and subnegotiations, followed by a long receiver hold-off and shaped random
// traffic.
// ----------------------------------------------------------------------------
module testbench;
  import tlr_pkg::*;

  localparam int LINE_LIMIT   = 4096;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int DRAIN_CYCLES = 16;

  // Parser modes of the predictor.
  typedef enum logic [2:0] {
    ST_TEXT, ST_CMD, ST_DONT, ST_DO, ST_WILL, ST_WONT, ST_SUB
  } rx_mode_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [11:0] position;
    logic [15:0] win_width;
    logic [15:0] win_height;
    logic        last;
  } request_t;

  logic clk;
  logic rst_n;

  tlr_byte_if   in_if ();
  tlr_result_if out_if ();

  telnet_line_receiver #(.LINE_MAX(LINE_LIMIT)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Predictor state.
  rx_mode_t   rx_mode;
  int         line_len;
  logic [7:0] sb_option;
  logic [2:0] sb_count;
  logic [7:0] naws_bytes [4];
  logic       ttype_halted;

  request_t expected_requests [$];
  request_t byte_requests [$];

  int  mismatches;
  int  cycle_count;
  bit  tx_idle;
  bit  rx_idle;
  int  rx_hold_cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run time limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  function automatic request_t make_req(input logic [2:0] kind, input logic [7:0] data,
                                        input logic [11:0] position,
                                        input logic [15:0] w, input logic [15:0] h);
    request_t r;
    r.kind       = kind;
    r.data       = data;
    r.position   = position;
    r.win_width  = w;
    r.win_height = h;
    r.last       = 1'b0;
    return r;
  endfunction

  task automatic add_wont(input logic [7:0] opt);
    byte_requests.push_back(make_req(K_REPLY, TN_IAC, '0, '0, '0));
    byte_requests.push_back(make_req(K_REPLY, TN_WONT, '0, '0, '0));
    byte_requests.push_back(make_req(K_REPLY, opt, '0, '0, '0));
  endtask

  // Line editing for a byte in text mode.
  task automatic decode_text(input logic [7:0] b);
    if (b == TN_IAC) begin
      rx_mode = ST_CMD;
    end else if (b <= CH_SPACE && line_len == 0) begin
      byte_requests.push_back(make_req(K_LINE_END, '0, '0, '0, '0));
    end else if ((b == CH_BS || b == CH_DEL) && line_len != 0) begin
      line_len--;
      byte_requests.push_back(make_req(K_ERASE, '0, line_len[11:0], '0, '0));
    end else if (b < CH_SPACE) begin
      byte_requests.push_back(make_req(K_LINE_END, '0, line_len[11:0], '0, '0));
      line_len = 0;
    end else begin
      byte_requests.push_back(make_req(K_APPEND, b, line_len[11:0], '0, '0));
      if (line_len + 2 >= LINE_LIMIT) begin
        byte_requests.push_back(make_req(K_LINE_END, '0, 12'(line_len + 1), '0, '0));
        line_len = 0;
      end else begin
        line_len++;
      end
    end
  endtask

  // Subnegotiation body: window size and terminal type.
  task automatic decode_sub(input logic [7:0] b);
    if (b == TN_SE) begin
      if (sb_count != 0 && sb_option == OPT_NAWS) begin
        byte_requests.push_back(make_req(K_WIN_SIZE, '0, '0,
                                         {naws_bytes[0], naws_bytes[1]},
                                         {naws_bytes[2], naws_bytes[3]}));
      end else if (sb_count != 0 && sb_option == OPT_TTYPE) begin
        byte_requests.push_back(make_req(K_TYPE_END, '0, '0, '0, '0));
      end
      rx_mode = ST_TEXT;
    end else begin
      if (sb_count == 0) begin
        sb_option = b;
      end else if (sb_option == OPT_NAWS) begin
        if (sb_count <= 3'd4) naws_bytes[2'(sb_count - 3'd1)] = b;
      end else if (sb_option == OPT_TTYPE && sb_count >= 3'd2) begin
        if (b == TN_IAC) begin
          ttype_halted = 1'b1;
        end else if (!ttype_halted) begin
          byte_requests.push_back(make_req(K_TYPE_CHAR, b, '0, '0, '0));
        end
      end
      if (sb_count < 3'd7) sb_count++;
    end
  endtask

  // Works out the requests caused by one accepted byte and queues them.
  task automatic decode_byte(input logic [7:0] b);
    byte_requests.delete();
    case (rx_mode)
      ST_TEXT: decode_text(b);
      ST_CMD: begin
        if (b == TN_DONT) rx_mode = ST_DONT;
        else if (b == TN_DO) rx_mode = ST_DO;
        else if (b == TN_WILL) rx_mode = ST_WILL;
        else if (b == TN_WONT) rx_mode = ST_WONT;
        else if (b == TN_SB) begin
          rx_mode      = ST_SUB;
          sb_option    = '0;
          sb_count     = '0;
          naws_bytes   = '{default: '0};
          ttype_halted = 1'b0;
        end else rx_mode = ST_TEXT;
      end
      ST_DONT: begin
        add_wont(b);
        rx_mode = ST_TEXT;
      end
      ST_DO: begin
        if (b == OPT_COMPRESS2) byte_requests.push_back(make_req(K_COMPRESS, 8'd2, '0, '0, '0));
        else if (b == OPT_COMPRESS1) byte_requests.push_back(make_req(K_COMPRESS, 8'd1, '0, '0, '0));
        else if (b != OPT_ECHO) add_wont(b);
        rx_mode = ST_TEXT;
      end
      ST_WILL: begin
        if (b == OPT_TTYPE) begin
          byte_requests.push_back(make_req(K_REPLY, TN_IAC, '0, '0, '0));
          byte_requests.push_back(make_req(K_REPLY, TN_SB, '0, '0, '0));
          byte_requests.push_back(make_req(K_REPLY, OPT_TTYPE, '0, '0, '0));
          byte_requests.push_back(make_req(K_REPLY, TTYPE_SEND, '0, '0, '0));
          byte_requests.push_back(make_req(K_REPLY, TN_IAC, '0, '0, '0));
          byte_requests.push_back(make_req(K_REPLY, TN_SE, '0, '0, '0));
        end
        rx_mode = ST_TEXT;
      end
      ST_SUB: decode_sub(b);
      default: rx_mode = ST_TEXT;
    endcase
    if (byte_requests.size() > 0) byte_requests[byte_requests.size() - 1].last = 1'b1;
    foreach (byte_requests[i]) expected_requests.push_back(byte_requests[i]);
  endtask

  // Sends one byte; entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    decode_byte(b);
    @(negedge clk);
  endtask

  // Receiver side: random stalls, plus a long hold-off on request.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        repeat (rx_hold_cycles - 1) @(negedge clk);
        rx_hold_cycles = 0;
      end else if (rx_idle && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    request_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_requests.size() == 0) begin
        report_mismatch($sformatf("request with none expected, kind %0d data %0d",
                                  out_if.kind, out_if.data));
      end else begin
        want = expected_requests.pop_front();
        if (out_if.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, wanted %0d", out_if.kind, want.kind));
        if (out_if.data !== want.data)
          report_mismatch($sformatf("data %0d, wanted %0d", out_if.data, want.data));
        if (out_if.position !== want.position)
          report_mismatch($sformatf("position %0d, wanted %0d",
                                    out_if.position, want.position));
        if (out_if.win_width !== want.win_width)
          report_mismatch($sformatf("width %0d, wanted %0d",
                                    out_if.win_width, want.win_width));
        if (out_if.win_height !== want.win_height)
          report_mismatch($sformatf("height %0d, wanted %0d",
                                    out_if.win_height, want.win_height));
        if (out_if.last !== want.last)
          report_mismatch($sformatf("last %0b, wanted %0b", out_if.last, want.last));
      end
    end
  end

  // A character that is appended whatever the line holds.
  function automatic logic [7:0] rand_printable();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(128, 254));
    return 8'($urandom_range(33, 126));
  endfunction

  function automatic logic [7:0] rand_option();
    case ($urandom_range(0, 7))
      0: return OPT_ECHO;
      1: return OPT_TTYPE;
      2: return OPT_NAWS;
      3: return OPT_COMPRESS1;
      4: return OPT_COMPRESS2;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Control bytes, erasing and a line of the highest character.
  task automatic test_line_editing();
    send_byte(CH_SPACE);
    send_byte(8'd65);
    send_byte(CH_DEL);
    send_byte(CH_DEL);
    send_byte(CH_BS);
    send_byte(8'd254);
    send_byte(8'd0);
    send_byte(8'd31);
  endtask

  // DONT, DO, WILL and IAC after IAC, with options that have their own reply.
  task automatic test_option_replies();
    send_byte(TN_IAC); send_byte(TN_DONT); send_byte(8'd0);
    send_byte(TN_IAC); send_byte(TN_DO);   send_byte(OPT_ECHO);
    send_byte(TN_IAC); send_byte(TN_DO);   send_byte(OPT_COMPRESS2);
    send_byte(TN_IAC); send_byte(TN_DO);   send_byte(OPT_COMPRESS1);
    send_byte(TN_IAC); send_byte(TN_DO);   send_byte(8'd255);
    send_byte(TN_IAC); send_byte(TN_WILL); send_byte(OPT_TTYPE);
    send_byte(TN_IAC); send_byte(TN_IAC);
  endtask

  // Window size with all bytes at their extremes, then a terminal type
  // that is cut short by IAC.
  task automatic test_subnegotiation();
    send_byte(TN_IAC); send_byte(TN_SB); send_byte(OPT_NAWS);
    send_byte(8'd255); send_byte(8'd0); send_byte(8'd0); send_byte(8'd255);
    send_byte(TN_SE);
    send_byte(TN_IAC); send_byte(TN_SB); send_byte(OPT_TTYPE); send_byte(8'd0);
    send_byte(8'd120); send_byte(TN_IAC); send_byte(8'd121); send_byte(TN_SE);
  endtask

  // The receiver holds off while replies pile up behind it.
  task automatic test_output_backpressure();
    rx_hold_cycles = 400;
    repeat (8) begin
      send_byte(TN_IAC); send_byte(TN_WILL); send_byte(OPT_TTYPE);
      send_byte(rand_printable());
    end
  endtask

  task automatic send_text_word();
    repeat ($urandom_range(1, 8)) send_byte(rand_printable());
    repeat ($urandom_range(0, 2)) send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
    if ($urandom_range(0, 2) != 0) send_byte(8'($urandom_range(0, 32)));
  endtask

  task automatic send_option();
    send_byte(TN_IAC);
    case ($urandom_range(0, 4))
      0: send_byte(TN_DONT);
      1: send_byte(TN_DO);
      2: send_byte(TN_WILL);
      3: send_byte(TN_WONT);
      default: send_byte(8'($urandom_range(0, 255)));
    endcase
    send_byte(rand_option());
  endtask

  task automatic send_subneg();
    logic [7:0] opt;
    int         len;
    opt = ($urandom_range(0, 3) == 0) ? rand_option() :
          ($urandom_range(0, 1) ? OPT_NAWS : OPT_TTYPE);
    len = $urandom_range(0, 9);
    send_byte(TN_IAC);
    send_byte(TN_SB);
    if ($urandom_range(0, 9) != 0) send_byte(opt);
    repeat (len) begin
      if ($urandom_range(0, 11) == 0) send_byte(TN_IAC);
      else if (opt == OPT_NAWS || $urandom_range(0, 5) == 0) send_byte(8'($urandom_range(0, 255)));
      else send_byte(rand_printable());
    end
    send_byte(TN_SE);
  endtask

  // Mostly well-formed sequences with random content, some noise.
  task automatic test_random_traffic(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin send_text_word(); sent += 6; end
        3, 4, 5: begin send_option(); sent += 3; end
        6, 7:    begin send_subneg(); sent += 8; end
        default: begin send_byte(8'($urandom_range(0, 255))); sent += 1; end
      endcase
      if ($urandom_range(0, 39) == 0) begin
        tx_idle = ~tx_idle;
        rx_idle = ~rx_idle;
      end
    end
  endtask

  // Main sequence.
  initial begin
    in_if.valid    = 1'b0;
    in_if.rx_byte  = '0;
    rst_n          = 1'b0;
    cycle_count    = 0;
    mismatches     = 0;
    tx_idle        = 1'b1;
    rx_idle        = 1'b1;
    rx_hold_cycles = 0;
    rx_mode        = ST_TEXT;
    line_len       = 0;
    sb_option      = '0;
    sb_count       = '0;
    naws_bytes     = '{default: '0};
    ttype_halted   = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_line_editing();
    test_option_replies();
    test_subnegotiation();
    test_output_backpressure();
    test_random_traffic(320);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    test_random_traffic(60);
    in_if.valid <= 1'b0;

    while (expected_requests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
